// ===== rtl/dbse_pkg.sv =====
// shared types, constants and codes of the dense bitmap set engine
package dbse_pkg;

   // fixed field widths
   localparam int OP_W   = 4;
   localparam int IDX_W  = 6;
   localparam int OPND_W = 64;
   localparam int ITEM_W = 12;

   // default geometry of the bitmap store
   localparam int DEFAULT_WORD_COUNT = 64;
   localparam int DEFAULT_WORD_BITS  = 64;

   // item count after reset
   localparam logic [ITEM_W-1:0] ITEM_COUNT_RESET = 12'd4095;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_CLEAR    = 4'd0,
      OP_FILL     = 4'd1,
      OP_ALLOCATE = 4'd2,
      OP_OR_IN    = 4'd3,
      OP_AND_IN   = 4'd4,
      OP_LOAD_OR  = 4'd5,
      OP_LOAD_AND = 4'd6,
      OP_WRITE    = 4'd7,
      OP_READ     = 4'd8,
      OP_MERGE    = 4'd9,
      OP_EQUAL    = 4'd10,
      OP_SUBSET   = 4'd11,
      OP_DISJOINT = 4'd12
   } op_type;

   // memory read source
   typedef enum logic [1:0] {
      RD_NONE = 2'd0,
      RD_REQ  = 2'd1,
      RD_WC   = 2'd2
   } rd_sel_type;

   // memory write source
   typedef enum logic [2:0] {
      WR_NONE  = 3'd0,
      WR_ZERO  = 3'd1,
      WR_FILL  = 3'd2,
      WR_OP    = 3'd3,
      WR_ALLOC = 3'd4
   } wr_sel_type;

   // what goes into the result register
   typedef enum logic [1:0] {
      RESP_ZERO  = 2'd0,
      RESP_WORD  = 2'd1,
      RESP_ALLOC = 2'd2
   } resp_sel_type;

   // controller to datapath
   typedef struct packed {
      logic         latch;
      logic         cnt_clear;
      logic         cnt_step;
      rd_sel_type   rd_sel;
      wr_sel_type   wr_sel;
      logic         resp_load;
      resp_sel_type resp_sel;
   } dbse_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic dec_clear;
      logic dec_fill;
      logic dec_alloc;
      logic dec_word;
      logic wc_last;
      logic alloc_hit;
      logic out_free;
   } dbse_status_type;

endpackage

// ===== rtl/dbse_ctrl.sv =====
// controller state machine of the dense bitmap set engine
module dbse_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dbse_pkg::dbse_status_type status,
   output dbse_pkg::dbse_cmd_type    cmd
);
   import dbse_pkg::*;

   typedef enum logic [7:0] {
      ST_INIT   = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_CLEAR  = 8'b0000_0100,
      ST_FILL   = 8'b0000_1000,
      ST_RZERO  = 8'b0001_0000,
      ST_AREAD  = 8'b0010_0000,
      ST_ACHECK = 8'b0100_0000,
      ST_WEXEC  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // input channel open only when idle
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.wr_sel = WR_ZERO;
            if (status.wc_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.cnt_step = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch     = 1'b1;
               cmd.cnt_clear = 1'b1;
               priority if (status.dec_clear) begin
                  state_in = ST_CLEAR;
               end else if (status.dec_fill) begin
                  state_in = ST_FILL;
               end else if (status.dec_alloc) begin
                  state_in = ST_AREAD;
               end else if (status.dec_word) begin
                  cmd.rd_sel = RD_REQ;
                  state_in   = ST_WEXEC;
               end else begin
                  state_in = ST_RZERO;
               end
            end
         end
         ST_CLEAR: begin
            cmd.wr_sel = WR_ZERO;
            if (status.wc_last) begin
               state_in = ST_RZERO;
            end else begin
               cmd.cnt_step = 1'b1;
            end
         end
         ST_FILL: begin
            cmd.wr_sel = WR_FILL;
            if (status.wc_last) begin
               state_in = ST_RZERO;
            end else begin
               cmd.cnt_step = 1'b1;
            end
         end
         ST_RZERO: begin
            if (status.out_free) begin
               cmd.resp_load = 1'b1;
               cmd.resp_sel  = RESP_ZERO;
               state_in      = ST_IDLE;
            end
         end
         ST_AREAD: begin
            cmd.rd_sel = RD_WC;
            state_in   = ST_ACHECK;
         end
         ST_ACHECK: begin
            priority if (status.alloc_hit || status.wc_last) begin
               if (status.out_free) begin
                  cmd.wr_sel    = status.alloc_hit ? WR_ALLOC : WR_NONE;
                  cmd.resp_load = 1'b1;
                  cmd.resp_sel  = RESP_ALLOC;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.cnt_step = 1'b1;
               state_in     = ST_AREAD;
            end
         end
         ST_WEXEC: begin
            if (status.out_free) begin
               cmd.wr_sel    = WR_OP;
               cmd.resp_load = 1'b1;
               cmd.resp_sel  = RESP_WORD;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/dbse_dpath.sv =====
// datapath of the dense bitmap set engine: bitmap memory, word unit, scan and result register
module dbse_dpath #(
   parameter int WORD_COUNT = dbse_pkg::DEFAULT_WORD_COUNT,
   parameter int WORD_BITS  = dbse_pkg::DEFAULT_WORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [dbse_pkg::ITEM_W-1:0]   csr_wr_data,
   input  logic [dbse_pkg::OP_W-1:0]     req_operation,
   input  logic [dbse_pkg::IDX_W-1:0]    req_word_index,
   input  logic [dbse_pkg::OPND_W-1:0]   req_operand_a,
   input  logic [dbse_pkg::OPND_W-1:0]   req_operand_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dbse_pkg::OPND_W-1:0]   rsp_result_word,
   output logic [dbse_pkg::ITEM_W-1:0]   rsp_item_number,
   output logic                          rsp_flag,
   input  dbse_pkg::dbse_cmd_type         cmd,
   output dbse_pkg::dbse_status_type      status
);
   import dbse_pkg::*;

   localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BASE_W = $clog2(WORD_COUNT * WORD_BITS);
   localparam int REM_W  = ((BASE_W > ITEM_W) ? BASE_W : ITEM_W) + 1;
   localparam int BIT_W  = $clog2(WORD_BITS);

   // configuration
   logic [ITEM_W-1:0]    item_count_ff;

   // latched item
   op_type               op_q;
   logic [ADDR_W-1:0]    idx_q;
   logic [WORD_BITS-1:0] opa_q;
   logic [WORD_BITS-1:0] opb_q;

   // sweep counter and item base of the current word
   logic [ADDR_W-1:0]    wc_ff;
   logic [ADDR_W-1:0]    wc_in;
   logic [BASE_W-1:0]    base_ff;
   logic [BASE_W-1:0]    base_in;

   // bitmap store
   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // running flag
   logic                 running_flag_ff;
   logic                 running_flag_in;

   // result register
   logic                 rsp_valid_ff;
   logic [OPND_W-1:0]    rsp_word_ff;
   logic [ITEM_W-1:0]    rsp_item_ff;
   logic                 rsp_flag_ff;

   // word unit
   logic [WORD_BITS-1:0] op_word;
   logic                 op_writes;
   logic                 test_val;
   logic                 test_is_or;
   logic                 test_upd;
   logic [WORD_BITS-1:0] word_res;

   // fill mask and first free search
   logic [REM_W-1:0]     rem;
   logic [WORD_BITS-1:0] fill_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_BITS-1:0] low_bit;
   logic [BIT_W-1:0]     bit_idx;
   logic [REM_W-1:0]     item_sum;
   logic [ITEM_W-1:0]    alloc_item;

   // decode of the offered item
   always_comb begin
      status.dec_clear = (req_operation == OP_CLEAR);
      status.dec_fill  = (req_operation == OP_FILL);
      status.dec_alloc = (req_operation == OP_ALLOCATE);
      status.dec_word  = (req_operation >= OP_OR_IN) && (req_operation <= OP_DISJOINT) &&
                         (32'(req_word_index) < WORD_COUNT);
      status.wc_last   = (wc_ff == ADDR_W'(WORD_COUNT - 1));
      status.alloc_hit = |free_bits;
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= ITEM_COUNT_RESET;
      end else if (csr_wr_en) begin
         item_count_ff <= csr_wr_data;
      end
   end

   // item latch
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_q  <= op_type'(req_operation);
         idx_q <= ADDR_W'(req_word_index);
         opa_q <= req_operand_a[WORD_BITS-1:0];
         opb_q <= req_operand_b[WORD_BITS-1:0];
      end
   end

   // sweep counter
   always_comb begin
      wc_in   = wc_ff;
      base_in = base_ff;
      if (cmd.cnt_clear) begin
         wc_in   = '0;
         base_in = '0;
      end else if (cmd.cnt_step) begin
         wc_in   = wc_ff + 1'b1;
         base_in = base_ff + BASE_W'(WORD_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff   <= '0;
         base_ff <= '0;
      end else begin
         wc_ff   <= wc_in;
         base_ff <= base_in;
      end
   end

   // items 1..item_count that fall in the current word
   always_comb begin
      rem = REM_W'(item_count_ff) - REM_W'(base_ff);
      for (int i = 0; i < WORD_BITS; i++) begin
         fill_mask[i] = !rem[REM_W-1] && (rem >= REM_W'(i)) && !((base_ff == '0) && (i == 0));
      end
   end

   // lowest free usable item of the word just read
   always_comb begin
      free_bits = ~rdata_ff & fill_mask;
      low_bit   = free_bits & (~free_bits + 1'b1);
      bit_idx   = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low_bit[i]) begin
            bit_idx = bit_idx | BIT_W'(i);
         end
      end
      item_sum   = REM_W'(base_ff) + REM_W'(bit_idx);
      alloc_item = ITEM_W'(item_sum);
   end

   // word operations on the stored word
   always_comb begin
      op_word    = rdata_ff;
      op_writes  = 1'b0;
      test_val   = 1'b0;
      test_is_or = 1'b0;
      test_upd   = 1'b0;
      word_res   = '0;
      unique case (op_q)
         OP_OR_IN: begin
            op_word   = rdata_ff | opa_q;
            op_writes = 1'b1;
         end
         OP_AND_IN: begin
            op_word   = rdata_ff & opa_q;
            op_writes = 1'b1;
         end
         OP_LOAD_OR: begin
            op_word   = opa_q | opb_q;
            op_writes = 1'b1;
         end
         OP_LOAD_AND: begin
            op_word   = opa_q & opb_q;
            op_writes = 1'b1;
         end
         OP_WRITE: begin
            op_word   = opa_q;
            op_writes = 1'b1;
         end
         OP_READ: begin
            word_res = rdata_ff;
         end
         OP_MERGE: begin
            op_word    = rdata_ff | opa_q;
            op_writes  = 1'b1;
            word_res   = opa_q & ~rdata_ff;
            test_val   = |(opa_q & ~rdata_ff);
            test_is_or = 1'b1;
            test_upd   = 1'b1;
         end
         OP_EQUAL: begin
            test_val = (rdata_ff == opa_q);
            test_upd = 1'b1;
         end
         OP_SUBSET: begin
            test_val = ((rdata_ff & ~opa_q) == '0);
            test_upd = 1'b1;
         end
         OP_DISJOINT: begin
            test_val = ((rdata_ff & opa_q) == '0);
            test_upd = 1'b1;
         end
         default: begin
            op_writes = 1'b0;
         end
      endcase
   end

   // running flag restarts at word zero
   always_comb begin
      running_flag_in = running_flag_ff;
      if (cmd.resp_load && (cmd.resp_sel == RESP_WORD) && test_upd) begin
         priority if (idx_q == '0) begin
            running_flag_in = test_val;
         end else if (test_is_or) begin
            running_flag_in = running_flag_ff | test_val;
         end else begin
            running_flag_in = running_flag_ff & test_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_flag_ff <= 1'b0;
      end else begin
         running_flag_ff <= running_flag_in;
      end
   end

   // memory port selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = wc_ff;
      unique case (cmd.rd_sel)
         RD_NONE: rd_en = 1'b0;
         RD_REQ: begin
            rd_en   = 1'b1;
            rd_addr = ADDR_W'(req_word_index);
         end
         RD_WC:   rd_en = 1'b1;
         default: rd_en = 1'b0;
      endcase

      wr_en   = 1'b0;
      wr_addr = wc_ff;
      wr_data = '0;
      unique case (cmd.wr_sel)
         WR_NONE: wr_en = 1'b0;
         WR_ZERO: wr_en = 1'b1;
         WR_FILL: begin
            wr_en   = 1'b1;
            wr_data = fill_mask;
         end
         WR_OP: begin
            wr_en   = op_writes;
            wr_addr = idx_q;
            wr_data = op_word;
         end
         WR_ALLOC: begin
            wr_en   = 1'b1;
            wr_data = rdata_ff | low_bit;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // bitmap memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // result register holds its beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.resp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         unique case (cmd.resp_sel)
            RESP_ZERO: begin
               rsp_word_ff <= '0;
               rsp_item_ff <= '0;
               rsp_flag_ff <= 1'b0;
            end
            RESP_WORD: begin
               rsp_word_ff <= OPND_W'(word_res);
               rsp_item_ff <= '0;
               rsp_flag_ff <= test_upd & running_flag_in;
            end
            RESP_ALLOC: begin
               rsp_word_ff <= '0;
               rsp_item_ff <= status.alloc_hit ? alloc_item : '0;
               rsp_flag_ff <= status.alloc_hit;
            end
            default: begin
               rsp_word_ff <= '0;
               rsp_item_ff <= '0;
               rsp_flag_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;
   assign rsp_item_number = rsp_item_ff;
   assign rsp_flag        = rsp_flag_ff;

endmodule

// ===== rtl/dense_bitmap_set_engine_unit.sv =====
// top level of the dense bitmap set engine
// Usage: items arrive on the req_ channel (valid/stall), one result beat per item
// leaves on the rsp_ channel. csr_wr_en with csr_wr_data sets item_count, which must be
// written only while the engine is idle; the block itself does not enforce this.
// Word operations (or_in .. disjoint): the accepted beat reads its word from the
// bitmap memory (one read port, one write port), then the word is computed and
// written back as the result is loaded; only then is a new item accepted.
// Clear and fill sweep the memory one word per cycle.
// Allocate scans word by word (read, then first free search) until it reaches
// the word that holds the lowest free item, or the last word.
// req_stall is high whenever an item is in progress.
// Reset: a clearing pass writes zero to every word with req_stall high;
// item_count returns to 4095 and the running flag to zero.
// A stalled result stays in the output register; the next item is still accepted
// and its work runs up to the point of delivering, where it waits for the register.
module dense_bitmap_set_engine_unit #(
   parameter int WORD_COUNT = dbse_pkg::DEFAULT_WORD_COUNT,
   parameter int WORD_BITS  = dbse_pkg::DEFAULT_WORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [dbse_pkg::ITEM_W-1:0]   csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [dbse_pkg::OP_W-1:0]     req_operation,
   input  logic [dbse_pkg::IDX_W-1:0]    req_word_index,
   input  logic [dbse_pkg::OPND_W-1:0]   req_operand_a,
   input  logic [dbse_pkg::OPND_W-1:0]   req_operand_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [dbse_pkg::OPND_W-1:0]   rsp_result_word,
   output logic [dbse_pkg::ITEM_W-1:0]   rsp_item_number,
   output logic                          rsp_flag
);
   import dbse_pkg::*;

   dbse_cmd_type    cmd;
   dbse_status_type status;

   // sequencer
   dbse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // store and word logic
   dbse_dpath #(
      .WORD_COUNT (WORD_COUNT),
      .WORD_BITS  (WORD_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_operation   (req_operation),
      .req_word_index  (req_word_index),
      .req_operand_a   (req_operand_a),
      .req_operand_b   (req_operand_b),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_word (rsp_result_word),
      .rsp_item_number (rsp_item_number),
      .rsp_flag        (rsp_flag),
      .cmd             (cmd),
      .status          (status)
   );

`ifndef NO_ASSERTIONS
   // a result is only loaded when the output register can take it
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.resp_load |-> status.out_free)
      else $error("result loaded over an untaken beat");

   // one item at a time: the channel closes after every accepted beat
   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input reopened straight after an accepted beat");

   // an allocated item always comes with the success flag
   a_alloc_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item_number != '0)) |-> rsp_flag)
      else $error("item number returned without success flag");

   // the clearing pass holds the input closed right after reset
   a_init_closed: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("input open during clearing pass");
`endif

endmodule
